// ===== design/nn_elastic_cross_section_unit_assert.svh =====
// assertion macros for the elastic cross section block and its checker
// expects clk and rst_n in the scope where a macro is used
`ifndef NN_ELASTIC_CROSS_SECTION_UNIT_ASSERT_SVH
`define NN_ELASTIC_CROSS_SECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define NNXS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NNXS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/nnxs_pkg.sv =====
// shared widths, register indexes, default masses, status codes, momentum bounds and centres
// no dependencies
`timescale 1ns / 1ps

package nnxs_pkg;

  localparam int E_W     = 19;
  localparam int MASS_W  = 20;
  localparam int XS_W    = 24;
  localparam int ST_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROTON_MASS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRON_MASS = 1'd1;

  localparam logic [MASS_W-1:0] PROTON_MASS_RST  = 20'd983850;
  localparam logic [MASS_W-1:0] NEUTRON_MASS_RST = 20'd985205;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_BELOW = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [XS_W-1:0] XS_MAX = 24'hFFFFFF;

  // plab in 2^-24 GeV
  localparam logic [26:0] PL_0425 = 27'd7130317;
  localparam logic [26:0] PL_0525 = 27'd8808038;
  localparam logic [26:0] PL_08   = 27'd13421773;
  localparam logic [26:0] PL_2    = 27'd33554432;
  localparam logic [26:0] PL_6    = 27'd100663296;
  localparam logic [26:0] PL_07   = 27'd11744051;
  localparam logic [26:0] PL_13   = 27'd21810381;
  localparam logic [26:0] PL_095  = 27'd15938355;

endpackage

// ===== design/nnxs_channels.sv =====
// valid/ready channel interfaces: pair input, result output, register writes
// depends on nnxs_pkg
`timescale 1ns / 1ps

interface nnxs_in_if;
  logic                        valid;
  logic                        ready;
  logic [nnxs_pkg::E_W-1:0]    pair_energy;
  logic                        first_is_neutron;
  logic                        second_is_neutron;
  modport source (output valid, pair_energy, first_is_neutron, second_is_neutron,
                  input ready);
  modport sink   (input valid, pair_energy, first_is_neutron, second_is_neutron,
                  output ready);
endinterface

interface nnxs_out_if;
  logic                        valid;
  logic                        ready;
  logic [nnxs_pkg::XS_W-1:0]   cross_section;
  logic [nnxs_pkg::ST_W-1:0]   status;
  modport source (output valid, cross_section, status, input ready);
  modport sink   (input valid, cross_section, status, output ready);
endinterface

interface nnxs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nnxs_pkg::CFG_IDX_W-1:0] index;
  logic [nnxs_pkg::MASS_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/nn_elastic_cross_section_unit.sv =====
// elastic nucleon-nucleon cross section pipeline, top level
// depends on nnxs_pkg and the channel interfaces in nnxs_channels.sv
//
// in_ch takes one word per cycle unless out_ch stalls: sqrt(s) in 2^-16 GeV and the two nucleon kinds.
// out_ch gives the cross section in 2^-8 mb (saturating) and a status code:
// ok, below threshold or momentum out of range (cross section then zero).
// cfg_ch writes the proton and neutron masses (2^-20 GeV); it is always ready.
// the user must write it only while no word is in flight; the block itself does not enforce this.
// 116 register stages; throughput: one word per cycle while out_ch is not stalled.
// the length is set by the digit-serial units, one step per stage: the
// threshold root (31), the plab divider (27), the branch root (26) and the
// branch divider (24).
// the whole pipe advances together; when out_ch stalls with a word waiting,
// every stage holds and in_ch.ready drops in the same cycle.
// synchronous reset clears all stage valid bits and loads the default masses.
`timescale 1ns / 1ps

module nn_elastic_cross_section_unit (
  input  logic        clk,
  input  logic        rst_n,
  nnxs_in_if.sink     in_ch,
  nnxs_out_if.source  out_ch,
  nnxs_cfg_if.sink    cfg_ch
);

  localparam int SQ1_N = 31;
  localparam int DV1_N = 27;
  localparam int SQ2_N = 26;
  localparam int DV2_N = 24;

  typedef enum logic [2:0] {
    BR_LIKE_LOW, BR_LIKE_MID, BR_LIKE_HI,
    BR_UNL_LOW, BR_UNL_MID, BR_UNL_HI, BR_FAR
  } br_t;

  typedef struct packed {
    logic [18:0] e;
    logic [20:0] m2;
    logic        like;
    logic [45:0] tu;
    logic        below;
    logic        mz;
  } thr_t;

  typedef struct packed {
    br_t         br;
    logic [1:0]  st;
    logic [20:0] m2;
    logic [45:0] tu;
    logic [26:0] p;
    logic [26:0] x;
    logic [29:0] d2;
  } evl_t;

  typedef struct packed {
    br_t         br;
    logic [1:0]  st;
    logic [15:0] bterm;
    logic [35:0] v;
    logic [23:0] mid;
  } fin_t;

  // configuration
  logic [nnxs_pkg::MASS_W-1:0] pmass_r, nmass_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmass_r <= nnxs_pkg::PROTON_MASS_RST;
      nmass_r <= nnxs_pkg::NEUTRON_MASS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        nnxs_pkg::REG_PROTON_MASS:  pmass_r <= cfg_ch.data;
        nnxs_pkg::REG_NEUTRON_MASS: nmass_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  logic [23:0] out_xs_r;
  logic [1:0]  out_st_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage a1: capture and mass sum
  logic        a1_v_r;
  logic [18:0] a1_e_r;
  logic        a1_like_r;
  logic [20:0] a1_m2_r;
  logic [19:0] m_a, m_b;

  assign m_a = in_ch.first_is_neutron  ? nmass_r : pmass_r;
  assign m_b = in_ch.second_is_neutron ? nmass_r : pmass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a1_v_r <= 1'b0;
    else if (adv) a1_v_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_e_r    <= in_ch.pair_energy;
      a1_like_r <= (in_ch.first_is_neutron == in_ch.second_is_neutron);
      a1_m2_r   <= {1'b0, m_a} + {1'b0, m_b};
    end
  end

  // stage a2: squares
  logic        a2_v_r;
  logic [18:0] a2_e_r;
  logic        a2_like_r;
  logic [20:0] a2_m2_r;
  logic [37:0] a2_ee_r;
  logic [41:0] a2_mm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a2_v_r <= 1'b0;
    else if (adv) a2_v_r <= a1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_e_r    <= a1_e_r;
      a2_like_r <= a1_like_r;
      a2_m2_r   <= a1_m2_r;
      a2_ee_r   <= 38'(a1_e_r) * 38'(a1_e_r);
      a2_mm_r   <= 42'(a1_m2_r) * 42'(a1_m2_r);
    end
  end

  // stage a3: threshold, loads the first root stage
  thr_t        sq1_sb_r   [0:SQ1_N];
  logic        sq1_v_r    [0:SQ1_N];
  logic [31:0] sq1_rem_r  [1:SQ1_N-1];
  logic [30:0] sq1_root_r [1:SQ1_N];
  logic [46:0] a3_t;
  thr_t        a3_sb;

  always_comb begin
    a3_t        = {1'b0, a2_ee_r, 8'b0} - {5'b0, a2_mm_r};
    a3_sb.e     = a2_e_r;
    a3_sb.m2    = a2_m2_r;
    a3_sb.like  = a2_like_r;
    a3_sb.tu    = a3_t[45:0];
    a3_sb.below = a3_t[46];
    a3_sb.mz    = (a2_m2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq1_v_r[0] <= 1'b0;
    else if (adv) sq1_v_r[0] <= a2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) sq1_sb_r[0] <= a3_sb;
  end

  // threshold root: one result bit per stage
  for (genvar k = 1; k <= SQ1_N; k++) begin : g_sq1
    logic [31:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] rad;
    logic [33:0] acc, trial, diff;
    logic        take;

    if (k == 1) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq1_rem_r[k-1];
      assign root_in = sq1_root_r[k-1];
    end

    assign rad   = {sq1_sb_r[k-1].tu, 16'b0};
    assign acc   = {rem_in, rad[2*(SQ1_N-k)+1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (acc >= trial);
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq1_v_r[k] <= 1'b0;
      else if (adv) sq1_v_r[k] <= sq1_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_root_r[k] <= {root_in[29:0], take};
        sq1_sb_r[k]   <= sq1_sb_r[k-1];
      end
    end

    if (k < SQ1_N) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) sq1_rem_r[k] <= take ? diff[31:0] : acc[31:0];
      end
    end
  end

  // stage c0: e * sqrt(threshold), then plab divider
  thr_t        dv1_sb_r  [0:DV1_N];
  logic        dv1_v_r   [0:DV1_N];
  logic [49:0] dv1_rem_r [0:DV1_N-1];
  logic [26:0] dv1_q_r   [1:DV1_N];
  logic        dv1_ovf_r [1:DV1_N];

  always_ff @(posedge clk) begin
    if (!rst_n) dv1_v_r[0] <= 1'b0;
    else if (adv) dv1_v_r[0] <= sq1_v_r[SQ1_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv1_sb_r[0]  <= sq1_sb_r[SQ1_N];
      dv1_rem_r[0] <= 50'(sq1_sb_r[SQ1_N].e) * 50'(sq1_root_r[SQ1_N]);
    end
  end

  for (genvar k = 1; k <= DV1_N; k++) begin : g_dv1
    logic [26:0] q_in;
    logic        ovf_in;
    logic [49:0] dsh;
    logic        take;

    if (k == 1) begin : g_first
      // quotient of 2^27 or more lies beyond the momentum range
      assign q_in   = '0;
      assign ovf_in = (dv1_rem_r[0] >= ({29'b0, dv1_sb_r[0].m2} << DV1_N));
    end else begin : g_next
      assign q_in   = dv1_q_r[k-1];
      assign ovf_in = dv1_ovf_r[k-1];
    end

    assign dsh  = {29'b0, dv1_sb_r[k-1].m2} << (DV1_N - k);
    assign take = (dv1_rem_r[k-1] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) dv1_v_r[k] <= 1'b0;
      else if (adv) dv1_v_r[k] <= dv1_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv1_q_r[k]   <= {q_in[25:0], take};
        dv1_ovf_r[k] <= ovf_in;
        dv1_sb_r[k]  <= dv1_sb_r[k-1];
      end
    end

    if (k < DV1_N) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) dv1_rem_r[k] <= take ? dv1_rem_r[k-1] - dsh : dv1_rem_r[k-1];
      end
    end
  end

  // stage d1: status, branch and distance from the branch centre
  logic        d1_v_r;
  evl_t        d1_sb_r;
  logic [26:0] d1_dabs_r;
  thr_t        d1_in;
  logic [26:0] d1_p;
  br_t         d1_br;
  logic [1:0]  d1_st;
  logic [26:0] d1_ctr, d1_dabs, d1_x;
  evl_t        d1_sb;

  assign d1_in = dv1_sb_r[DV1_N];
  assign d1_p  = dv1_q_r[DV1_N];

  always_comb begin
    if (d1_in.below) begin
      d1_st = nnxs_pkg::ST_BELOW;
    end else if (d1_in.mz || dv1_ovf_r[DV1_N] || (d1_p >= nnxs_pkg::PL_6)) begin
      d1_st = nnxs_pkg::ST_RANGE;
    end else begin
      d1_st = nnxs_pkg::ST_OK;
    end

    if (d1_in.like) begin
      priority if (d1_p < nnxs_pkg::PL_0425) d1_br = BR_LIKE_LOW;
      else if (d1_p < nnxs_pkg::PL_08)      d1_br = BR_LIKE_MID;
      else if (d1_p < nnxs_pkg::PL_2)       d1_br = BR_LIKE_HI;
      else                                  d1_br = BR_FAR;
    end else begin
      priority if (d1_p < nnxs_pkg::PL_0525) d1_br = BR_UNL_LOW;
      else if (d1_p < nnxs_pkg::PL_08)      d1_br = BR_UNL_MID;
      else if (d1_p < nnxs_pkg::PL_2)       d1_br = BR_UNL_HI;
      else                                  d1_br = BR_FAR;
    end

    unique case (d1_br)
      BR_LIKE_MID: d1_ctr = nnxs_pkg::PL_07;
      BR_LIKE_HI:  d1_ctr = nnxs_pkg::PL_13;
      BR_UNL_MID:  d1_ctr = nnxs_pkg::PL_095;
      default:     d1_ctr = '0;
    endcase

    d1_dabs = (d1_p >= d1_ctr) ? d1_p - d1_ctr : d1_ctr - d1_p;

    unique case (d1_br)
      BR_UNL_MID: d1_x = d1_dabs;
      BR_UNL_HI:  d1_x = d1_p;
      default:    d1_x = '0;
    endcase

    d1_sb.br = d1_br;
    d1_sb.st = d1_st;
    d1_sb.m2 = d1_in.m2;
    d1_sb.tu = d1_in.tu;
    d1_sb.p  = d1_p;
    d1_sb.x  = d1_x;
    d1_sb.d2 = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= 1'b0;
    else if (adv) d1_v_r <= dv1_v_r[DV1_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_sb_r   <= d1_sb;
      d1_dabs_r <= d1_dabs;
    end
  end

  // stage e0: squared distance, loads the branch root
  evl_t        sq2_sb_r   [0:SQ2_N];
  logic        sq2_v_r    [0:SQ2_N];
  logic [26:0] sq2_rem_r  [1:SQ2_N-1];
  logic [25:0] sq2_root_r [1:SQ2_N];
  logic [53:0] e0_sq;
  evl_t        e0_sb;

  always_comb begin
    e0_sq    = 54'(d1_dabs_r) * 54'(d1_dabs_r);
    e0_sb    = d1_sb_r;
    e0_sb.d2 = e0_sq[53:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq2_v_r[0] <= 1'b0;
    else if (adv) sq2_v_r[0] <= d1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) sq2_sb_r[0] <= e0_sb;
  end

  for (genvar k = 1; k <= SQ2_N; k++) begin : g_sq2
    logic [26:0] rem_in;
    logic [25:0] root_in;
    logic [51:0] rad;
    logic [28:0] acc, trial, diff;
    logic        take;

    if (k == 1) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq2_rem_r[k-1];
      assign root_in = sq2_root_r[k-1];
    end

    assign rad   = {1'b0, sq2_sb_r[k-1].x, 24'b0};
    assign acc   = {rem_in, rad[2*(SQ2_N-k)+1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (acc >= trial);
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq2_v_r[k] <= 1'b0;
      else if (adv) sq2_v_r[k] <= sq2_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_root_r[k] <= {root_in[24:0], take};
        sq2_sb_r[k]   <= sq2_sb_r[k-1];
      end
    end

    if (k < SQ2_N) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) sq2_rem_r[k] <= take ? diff[26:0] : acc[26:0];
      end
    end
  end

  // stage f0: polynomial product and divider operands per branch
  fin_t        dv2_sb_r  [0:DV2_N];
  logic        dv2_v_r   [0:DV2_N];
  logic [58:0] dv2_rem_r [0:DV2_N-1];
  logic [52:0] dv2_den_r [0:DV2_N-1];
  logic [23:0] dv2_q_r   [1:DV2_N];
  logic        dv2_sat_r [1:DV2_N];
  evl_t        f0_in;
  logic [25:0] f0_s;
  logic [29:0] f0_mulb;
  logic [59:0] f0_prod;
  logic [58:0] f0_num;
  logic [52:0] f0_den;
  logic [31:0] f0_m1705;
  fin_t        f0_sb;

  assign f0_in = sq2_sb_r[SQ2_N];
  assign f0_s  = sq2_root_r[SQ2_N];

  always_comb begin
    f0_mulb  = (f0_in.br == BR_UNL_MID) ? {4'b0, f0_s} : f0_in.d2;
    f0_prod  = 60'(f0_in.d2) * 60'(f0_mulb);
    f0_m1705 = 32'(f0_in.m2) * 32'd1705;

    unique case (f0_in.br)
      BR_LIKE_LOW: begin
        f0_num = {2'b0, f0_in.m2, 36'b0};
        f0_den = 53'(f0_in.tu) * 53'd100;
      end
      BR_UNL_LOW: begin
        f0_num = {f0_m1705, 27'b0};
        f0_den = 53'(f0_in.tu) * 53'd100;
      end
      BR_LIKE_HI: begin
        f0_num = 59'(1250) << 32;
        f0_den = 53'(f0_in.p) + (53'd50 << 24);
      end
      BR_UNL_HI: begin
        f0_num = 59'(31) << 32;
        f0_den = 53'(f0_s);
      end
      BR_FAR: begin
        f0_num = 59'(77) << 32;
        f0_den = 53'(f0_in.p) + (53'd3 << 23);
      end
      default: begin
        f0_num = '0;
        f0_den = '0;
      end
    endcase

    f0_sb.br    = f0_in.br;
    f0_sb.st    = f0_in.st;
    f0_sb.bterm = f0_in.d2[29:14];
    f0_sb.v     = f0_prod[59:24];
    f0_sb.mid   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv2_v_r[0] <= 1'b0;
    else if (adv) dv2_v_r[0] <= sq2_v_r[SQ2_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv2_sb_r[0]  <= f0_sb;
      dv2_rem_r[0] <= f0_num;
      dv2_den_r[0] <= f0_den;
    end
  end

  for (genvar k = 1; k <= DV2_N; k++) begin : g_dv2
    logic [23:0] q_in;
    logic        sat_in;
    logic [76:0] dsh;
    logic        take;
    fin_t        sb_out;

    if (k == 1) begin : g_first
      logic [45:0] wprod;
      logic [30:0] wsum;
      // quotient of 2^24 or more saturates
      assign q_in   = '0;
      assign sat_in = ({18'b0, dv2_rem_r[0]} >= {dv2_den_r[0], 24'b0});
      // mid-momentum polynomial finishes alongside the first divide step
      always_comb begin
        wprod = 46'(dv2_sb_r[0].v) *
                ((dv2_sb_r[0].br == BR_LIKE_MID) ? 46'd1000 : 46'd196);
        wsum  = {1'b0, wprod[45:16]} +
                ((dv2_sb_r[0].br == BR_LIKE_MID) ? 31'd6016 : 31'd8448);
        sb_out     = dv2_sb_r[0];
        sb_out.mid = (wsum > 31'(nnxs_pkg::XS_MAX)) ? nnxs_pkg::XS_MAX : wsum[23:0];
      end
    end else begin : g_next
      assign q_in   = dv2_q_r[k-1];
      assign sat_in = dv2_sat_r[k-1];
      assign sb_out = dv2_sb_r[k-1];
    end

    assign dsh  = {24'b0, dv2_den_r[k-1]} << (DV2_N - k);
    assign take = ({18'b0, dv2_rem_r[k-1]} >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) dv2_v_r[k] <= 1'b0;
      else if (adv) dv2_v_r[k] <= dv2_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv2_q_r[k]   <= {q_in[22:0], take};
        dv2_sat_r[k] <= sat_in;
        dv2_sb_r[k]  <= sb_out;
      end
    end

    if (k < DV2_N) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          dv2_rem_r[k] <= take ? dv2_rem_r[k-1] - dsh[58:0] : dv2_rem_r[k-1];
          dv2_den_r[k] <= dv2_den_r[k-1];
        end
      end
    end
  end

  // output stage: per-branch finish, saturation and flag override
  fin_t        g_sb;
  logic [23:0] g_q;
  logic        g_sat;
  logic [24:0] g_qa;
  logic [23:0] g_bt;
  logic [23:0] g_xs;

  assign g_sb  = dv2_sb_r[DV2_N];
  assign g_q   = dv2_q_r[DV2_N];
  assign g_sat = dv2_sat_r[DV2_N];

  always_comb begin
    g_qa = {1'b0, g_q} + 25'd428;
    g_bt = {8'b0, g_sb.bterm};
    unique case (g_sb.br)
      BR_LIKE_LOW: begin
        if (g_sat || g_qa[24]) g_xs = nnxs_pkg::XS_MAX;
        else                   g_xs = g_qa[23:0];
      end
      BR_UNL_LOW: begin
        if (g_sat)                g_xs = nnxs_pkg::XS_MAX;
        else if (g_q < 24'd1748)  g_xs = '0;
        else                      g_xs = g_q - 24'd1748;
      end
      BR_LIKE_MID, BR_UNL_MID: g_xs = g_sb.mid;
      BR_LIKE_HI:  g_xs = (g_q > g_bt) ? g_q - g_bt : '0;
      BR_UNL_HI, BR_FAR: g_xs = g_sat ? nnxs_pkg::XS_MAX : g_q;
      default:     g_xs = '0;
    endcase
    if (g_sb.st != nnxs_pkg::ST_OK) g_xs = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv2_v_r[DV2_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_xs_r <= g_xs;
      out_st_r <= g_sb.st;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cross_section = out_xs_r;
  assign out_ch.status        = out_st_r;

endmodule

// ===== design/nnxs_checker.sv =====
// port-level checks for the elastic cross section block, bound to the top level
// depends on nnxs_pkg and nn_elastic_cross_section_unit_assert.svh
`timescale 1ns / 1ps
`include "nn_elastic_cross_section_unit_assert.svh"

module nnxs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_cross_section,
  input logic [1:0]  out_status,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result word stays put
  `NNXS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cross_section) && $stable(out_status), "result word changed while stalled")

  // flagged words carry no cross section
  `NNXS_ASSERT_NOW(a_flag_zero, out_valid && (out_status != nnxs_pkg::ST_OK), out_cross_section == '0, "flagged result with nonzero cross section")

  // back-pressure only comes from a waiting result
  `NNXS_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input held off with empty output")

  `NNXS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write refused")

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind nn_elastic_cross_section_unit nnxs_checker u_nnxs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_cross_section (out_ch.cross_section),
  .out_status        (out_ch.status),
  .cfg_valid         (cfg_ch.valid),
  .cfg_ready         (cfg_ch.ready)
);
